@@ src/bmp_pkg.sv @@
// bmp_pkg: shared widths, constants, control types and states for the pascal
// triangle modular binomial block. No dependencies.
`default_nettype none

package bmp_pkg;

	localparam int WORD_W      = 62;
	localparam int IDX_W       = 10;
	localparam int MAX_ROW_DEF = 1023;
	localparam int GRP_SIZE    = 32;
	localparam int GRP_IDX_W   = 5;

	localparam logic [WORD_W-1:0] MOD_RESET = 62'd1000000007;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_PICK1,
		ST_PICK2,
		ST_DONE
	} bmp_state_t;

	// control broadcast to every cell
	typedef struct packed {
		logic start;
		logic en;
	} bmp_cell_ctl_t;

endpackage

`default_nettype wire

@@ src/bmp_ifs.sv @@
// bmp_ifs: valid/ready channel interfaces for the query and result words.
// Depends on bmp_pkg.
`default_nettype none

interface bmp_query_if import bmp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] row_index;
	logic [IDX_W-1:0] col_index;

	modport source (output valid, output row_index, output col_index, input ready);
	modport sink   (input valid, input row_index, input col_index, output ready);
endinterface

interface bmp_result_if import bmp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] coefficient;
	logic              in_range;

	modport source (output valid, output coefficient, output in_range, input ready);
	modport sink   (input valid, input coefficient, input in_range, output ready);
endinterface

`default_nettype wire

@@ src/bmp_cell.sv @@
// bmp_cell: one column of the pascal triangle row, updated once per row step.
// Depends on bmp_pkg.
`default_nettype none

module bmp_cell import bmp_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire bmp_cell_ctl_t        ctl,
	input  wire logic [WORD_W-1:0]    modulus,
	input  wire logic [WORD_W-1:0]    one,
	input  wire logic [WORD_W-1:0]    left_val,
	input  wire logic                 left_tok,
	output logic      [WORD_W-1:0]    val,
	output logic                      tok
);

	logic [WORD_W-1:0] val_q;
	logic              tok_q;
	logic [WORD_W:0]   sum;
	logic [WORD_W:0]   diff;
	logic [WORD_W-1:0] val_d;

	// modular add of the upper-left and upper entries, or the edge value where the row-edge marker arrives
	always_comb begin
		sum  = {1'b0, left_val} + {1'b0, val_q};
		diff = sum - {1'b0, modulus};
		if (left_tok) begin
			val_d = one;
		end else if (sum >= {1'b0, modulus}) begin
			val_d = diff[WORD_W-1:0];
		end else begin
			val_d = sum[WORD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			val_q <= val_d;
		end
	end

	// row-edge marker moves one cell right per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (ctl.start) begin
			tok_q <= 1'b0;
		end else if (ctl.en) begin
			tok_q <= left_tok;
		end
	end

	assign val = val_q;
	assign tok = tok_q;

endmodule

`default_nettype wire

@@ src/bmp_colsel.sv @@
// bmp_colsel: two-stage registered column select over the cell row.
// Depends on bmp_pkg.
`default_nettype none

module bmp_colsel import bmp_pkg::*; #(
	parameter int NCELL = MAX_ROW_DEF + 1
) (
	input  wire logic              clk,
	input  wire logic [WORD_W-1:0] vals [NCELL],
	input  wire logic [IDX_W-1:0]  col,
	output logic      [WORD_W-1:0] sel
);

	localparam int GW   = (NCELL > GRP_SIZE) ? $clog2((NCELL + GRP_SIZE - 1) / GRP_SIZE) : 1;
	localparam int NGRP = 2 ** GW;
	localparam int NPAD = NGRP * GRP_SIZE;

	logic [WORD_W-1:0] pad    [NPAD];
	logic [WORD_W-1:0] grp_s1 [NGRP];
	logic [WORD_W-1:0] sel_s2;

	for (genvar i = 0; i < NPAD; i++) begin : g_pad
		if (i < NCELL) begin : g_real
			assign pad[i] = vals[i];
		end else begin : g_zero
			assign pad[i] = '0;
		end
	end

	// stage 1: pick within each group of 32
	always_ff @(posedge clk) begin
		for (int g = 0; g < NGRP; g++) begin
			grp_s1[g] <= pad[{GW'(g), col[GRP_IDX_W-1:0]}];
		end
	end

	// stage 2: pick the group
	always_ff @(posedge clk) begin
		sel_s2 <= grp_s1[col[GRP_IDX_W +: GW]];
	end

	assign sel = sel_s2;

endmodule

`default_nettype wire

@@ src/binomial_mod_pascal_top.sv @@
// binomial_mod_pascal_top: C(n,k) mod M by pascal triangle in a row of cells.
// Depends on bmp_pkg, bmp_ifs, bmp_cell, bmp_colsel.
//
//   channel   dir   handshake      word
//   qry       in    valid/ready    row_index[9:0], col_index[9:0]
//   res       out   valid/ready    coefficient[61:0], in_range
//   cfg       in    cfg_we         cfg_wdata[61:0] (modulus)
//
// a word with k <= n <= MAX_ROW takes n+1 row steps through the cell row,
// one row per cycle, then passes the column select and the hand-off
// a word with k > n or n > MAX_ROW skips the row and goes to the hand-off
// one word is in work at a time; ready is high while idle, even if the
// output register still holds an untaken result
// reset restores the modulus to 1000000007; the cells need no clearing
`default_nettype none

module binomial_mod_pascal_top import bmp_pkg::*; #(
	parameter int MAX_ROW = MAX_ROW_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [WORD_W-1:0] cfg_wdata,
	bmp_query_if.sink              qry,
	bmp_result_if.source           res
);

	// only rows up to 1023 can be asked for, so no more cells than row 1023 needs
	localparam int NCELL = ((MAX_ROW < 1023) ? MAX_ROW : 1023) + 1;

	// effective modulus (zero acts as one) and the edge value
	logic [WORD_W-1:0] mod_q;
	logic [WORD_W-1:0] one_q;

	bmp_state_t        state_q;
	bmp_state_t        state_d;
	logic [IDX_W-1:0]  n_q;
	logic [IDX_W-1:0]  k_q;
	logic [IDX_W-1:0]  cnt_q;
	logic              inr_q;
	logic              run_q;

	logic              out_vld_q;
	logic [WORD_W-1:0] coef_q;
	logic              res_inr_q;

	logic              accept;
	logic              load_out;
	logic              first;
	bmp_cell_ctl_t     ctl;

	logic [WORD_W-1:0] cell_val [NCELL];
	logic [NCELL-1:0]  cell_tok;
	logic [WORD_W-1:0] sel;

	logic              inr_new;
	logic              run_new;

	assign accept  = qry.valid && qry.ready;
	assign inr_new = (qry.col_index <= qry.row_index);
	assign run_new = inr_new && (int'(qry.row_index) <= MAX_ROW);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MOD_RESET;
			one_q <= {{(WORD_W-1){1'b0}}, 1'b1};
		end else if (cfg_we) begin
			if (cfg_wdata == '0) begin
				mod_q <= {{(WORD_W-1){1'b0}}, 1'b1};
			end else begin
				mod_q <= cfg_wdata;
			end
			// modulus of one (or zero) makes every entry zero
			if (cfg_wdata <= {{(WORD_W-1){1'b0}}, 1'b1}) begin
				one_q <= '0;
			end else begin
				one_q <= {{(WORD_W-1){1'b0}}, 1'b1};
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = run_new ? ST_RUN : ST_DONE;
				end
			end
			ST_RUN: begin
				if (cnt_q == n_q) begin
					state_d = ST_PICK1;
				end
			end
			ST_PICK1: state_d = ST_PICK2;
			ST_PICK2: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_vld_q || res.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		qry.ready = 1'b0;
		ctl.start = 1'b0;
		ctl.en    = 1'b0;
		first     = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				qry.ready = 1'b1;
				ctl.start = qry.valid;
			end
			ST_RUN: begin
				ctl.en = 1'b1;
				first  = (cnt_q == '0);
			end
			ST_DONE: begin
				load_out = !out_vld_q || res.ready;
			end
			default: begin
				qry.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			inr_q   <= 1'b0;
			run_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
				inr_q <= inr_new;
				run_q <= run_new;
			end else if (state_q == ST_RUN && cnt_q != n_q) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// query word, held for the whole run
	always_ff @(posedge clk) begin
		if (accept) begin
			n_q <= qry.row_index;
			k_q <= qry.col_index;
		end
	end

	// the cell row: cell j holds entry j of the current row
	for (genvar j = 0; j < NCELL; j++) begin : g_cell
		logic [WORD_W-1:0] left_val;
		logic              left_tok;
		if (j == 0) begin : g_head
			// nothing left of column 0; the row-0 marker enters here
			assign left_val = '0;
			assign left_tok = first;
		end else begin : g_body
			assign left_val = cell_val[j-1];
			assign left_tok = cell_tok[j-1];
		end
		bmp_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.modulus  (mod_q),
			.one      (one_q),
			.left_val (left_val),
			.left_tok (left_tok),
			.val      (cell_val[j]),
			.tok      (cell_tok[j])
		);
	end

	// column k after the last row step
	bmp_colsel #(
		.NCELL (NCELL)
	) u_colsel (
		.clk  (clk),
		.vals (cell_val),
		.col  (k_q),
		.sel  (sel)
	);

	// output register, frees the input side while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			coef_q    <= run_q ? sel : '0;
			res_inr_q <= inr_q;
		end
	end

	assign res.valid       = out_vld_q;
	assign res.coefficient = coef_q;
	assign res.in_range    = res_inr_q;

	// a column past the row never reports a nonzero coefficient
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.in_range |-> res.coefficient == '0)
		else $error("out of range word with nonzero coefficient");

	// the row counter never runs past the requested row
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> cnt_q <= n_q)
		else $error("row counter past requested row");

	// at most one row-edge marker in the cell row
	a_tok_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_tok))
		else $error("more than one row-edge marker");

	// a finished word always lands in the output register
	a_done_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && (!out_vld_q || res.ready) |=> res.valid)
		else $error("finished word not presented");

endmodule

`default_nettype wire
